// ===== hdl/shni_pkg.sv =====
// Package for the stereo hiss noise injector: widths, filter coefficients,
// register indexes and the controller/datapath command and status types.
// No dependencies.
package shni_pkg;

  // One sample port per channel on the top level, so the channel count is fixed.
  localparam int NUM_CHANNELS     = 2;
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int CFG_IDX_BITS     = 2;
  localparam int CFG_DATA_BITS    = 32;
  localparam int TAP_BITS         = 24;
  localparam int PINK_POLES       = 6;

  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOR = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLEND = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEED  = 2'd3;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] COLOR_MIN = 17'd66;
  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_ADD   = 32'd1013904223;

  localparam logic signed [25:0] DIRECT_C    = 26'sd8995943;
  localparam logic signed [25:0] LAST_C      = 26'sd1944916;
  localparam logic signed [25:0] OUT_SCALE_C = 26'sd1845494;

  function automatic logic signed [25:0] pole_c(input logic [2:0] k);
    case (k)
      3'd0:    pole_c = 26'sd16758090;
      3'd1:    pole_c = 26'sd16665144;
      3'd2:    pole_c = 26'sd16257122;
      3'd3:    pole_c = 26'sd14537458;
      3'd4:    pole_c = 26'sd9227469;
      3'd5:    pole_c = -26'sd12777528;
      default: pole_c = 26'sd0;
    endcase
  endfunction

  function automatic logic signed [25:0] feed_c(input logic [2:0] k);
    case (k)
      3'd0:    feed_c = 26'sd931436;
      3'd1:    feed_c = 26'sd1259565;
      3'd2:    feed_c = 26'sd2581208;
      3'd3:    feed_c = 26'sd5209084;
      3'd4:    feed_c = 26'sd8941454;
      3'd5:    feed_c = -26'sd283501;
      default: feed_c = 26'sd0;
    endcase
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture input word and registers
    logic draw;      // step the generator and take white for current channel
    logic pole;      // update one pole tap, index tap_idx
    logic pink_sum;  // direct term and last tap
    logic pink_out;  // output scale product
    logic mix;       // colour mix into channel noise
    logic next_ch;   // advance channel index
    logic mono;      // form mono mean
    logic blend;     // blend product for current channel
    logic gain;      // gain product for current channel
    logic outp;      // saturate and store output sample
    logic present;   // raise output valid
    logic [2:0] tap_idx;
  } shni_cmd_t;

  typedef struct packed {
    logic bypass;
    logic white_only;
    logic last_ch;
  } shni_sts_t;

endpackage

// ===== hdl/shni_ctrl.sv =====
// Controller state machine for the hiss injector.
// Depends on shni_pkg; drives shni_dp through shni_cmd_t.
module shni_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_busy,
  input  shni_pkg::shni_sts_t sts,
  output shni_pkg::shni_cmd_t cmd
);
  import shni_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DRAW  = 11'b00000000010,
    S_POLE  = 11'b00000000100,
    S_PSUM  = 11'b00000001000,
    S_POUT  = 11'b00000010000,
    S_MIX   = 11'b00000100000,
    S_MONO  = 11'b00001000000,
    S_BLEND = 11'b00010000000,
    S_GAIN  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] tap_r, tap_nxt;

  // A new word is taken only when the output register is free to receive it.
  assign in_ready = (state_r == S_IDLE) && !out_busy;

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    cmd       = '0;
    cmd.tap_idx = tap_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        if (sts.bypass) begin
          cmd.present = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.draw  = 1'b1;
          tap_nxt   = 3'd0;
          state_nxt = sts.white_only ? S_MIX : S_POLE;
        end
      end
      S_POLE: begin
        cmd.pole = 1'b1;
        tap_nxt  = tap_r + 3'd1;
        if (tap_r == 3'(PINK_POLES - 1)) state_nxt = S_PSUM;
      end
      S_PSUM: begin
        cmd.pink_sum = 1'b1;
        state_nxt    = S_POUT;
      end
      S_POUT: begin
        cmd.pink_out = 1'b1;
        state_nxt    = S_MIX;
      end
      S_MIX: begin
        cmd.mix     = 1'b1;
        cmd.next_ch = !sts.last_ch;
        state_nxt   = sts.last_ch ? S_MONO : S_DRAW;
      end
      S_MONO: begin
        cmd.mono  = 1'b1;
        state_nxt = S_BLEND;
      end
      S_BLEND: begin
        cmd.blend = 1'b1;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.outp    = 1'b1;
        cmd.next_ch = !sts.last_ch;
        state_nxt   = sts.last_ch ? S_DONE : S_BLEND;
      end
      S_DONE: begin
        cmd.present = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

endmodule

// ===== hdl/shni_dp.sv =====
// Datapath of the hiss injector: registers, generator, pink taps and the
// shared arithmetic steps. Depends on shni_pkg; sequenced by shni_ctrl.
module shni_dp #(
  parameter int SAMPLE_BITS  = shni_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [shni_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [shni_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]         in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]         in_right_in,
  input  shni_pkg::shni_cmd_t                   cmd,
  output shni_pkg::shni_sts_t                   sts,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [SAMPLE_BITS-1:0]         out_left_out,
  output logic signed [SAMPLE_BITS-1:0]         out_right_out
);
  import shni_pkg::*;

  localparam int CH_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NB      = 48;  // wide noise word
  localparam int PB      = 34;  // noise operand width of the mix, blend and gain products
  localparam int SHIFT_UP = (SAMPLE_BITS >= 24) ? SAMPLE_BITS - 24 : 0;
  localparam int SHIFT_DN = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;

  logic [16:0] gain_r, mix_r, blend_r;
  logic [31:0] rng_r;
  logic signed [TAP_BITS-1:0] taps_r [NUM_CHANNELS][7];
  logic signed [SAMPLE_BITS-1:0] x_r [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y_r [NUM_CHANNELS];
  logic signed [NB-1:0] nz_r [NUM_CHANNELS];
  logic [CH_BITS-1:0] ch_r;
  logic signed [24:0] white_r;
  logic signed [34:0] acc_r;     // pink accumulator, Q.23
  logic signed [PB-1:0] pink_r;
  logic signed [NB-1:0] mono_r, blend_res_r, s_r;
  logic [16:0] gain_c, mix_c, blend_c;
  logic busy_r;

  assign gain_c  = (gain_r > ONE_Q16) ? ONE_Q16 : gain_r;
  assign mix_c   = (mix_r > ONE_Q16) ? ONE_Q16 : mix_r;
  assign blend_c = (blend_r > ONE_Q16) ? ONE_Q16 : blend_r;

  assign sts.bypass     = (gain_c == 17'd0);
  assign sts.white_only = (mix_c < COLOR_MIN);
  assign sts.last_ch    = (ch_r == CH_BITS'(NUM_CHANNELS - 1));

  function automatic logic signed [NB-1:0] sat_out(input logic signed [NB-1:0] v);
    logic signed [NB-1:0] hi, lo;
    hi = (NB'(1) <<< (SAMPLE_BITS - 1)) - NB'(1);
    lo = -hi - NB'(1);
    sat_out = (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Generator step.
  logic [31:0] rng_next;
  assign rng_next = rng_r * LCG_MUL + LCG_ADD;

  // Pole tap update for the current channel and tap.
  logic signed [TAP_BITS-1:0] tap_cur;
  logic signed [49:0] pole_pr;
  logic signed [50:0] feed_pr;
  logic signed [63:0] pole_acc, pole_rnd;
  logic signed [TAP_BITS-1:0] pole_sat;
  assign tap_cur  = taps_r[ch_r][cmd.tap_idx];
  assign pole_pr  = pole_c(cmd.tap_idx) * tap_cur;
  assign feed_pr  = feed_c(cmd.tap_idx) * white_r;
  assign pole_acc = (64'(pole_pr) <<< 6) + 64'(feed_pr);
  assign pole_rnd = (pole_acc + 64'sd536870912) >>> 30;
  assign pole_sat = (pole_rnd > 64'sd8388607) ? 24'sh7fffff :
                    (pole_rnd < -64'sd8388608) ? 24'sh800000 : pole_rnd[TAP_BITS-1:0];

  // Tap sum, direct term and last tap (taps already hold the new poles).
  logic signed [31:0] tap_sum;
  logic signed [50:0] direct_pr, last_p;
  logic signed [63:0] sum_acc;
  logic signed [63:0] last_rnd;
  always_comb begin
    tap_sum = '0;
    for (int k = 0; k < 7; k++) tap_sum = tap_sum + 32'(taps_r[ch_r][k]);
  end
  assign direct_pr = DIRECT_C * white_r;
  assign sum_acc   = ((64'(tap_sum) <<< 30) + 64'(direct_pr) + 64'sd8388608) >>> 24;
  assign last_p    = LAST_C * white_r;
  assign last_rnd  = (64'(last_p) + 64'sd536870912) >>> 30;

  logic signed [60:0] pout_pr;
  logic signed [63:0] pout_p;
  assign pout_pr = acc_r * OUT_SCALE_C;
  assign pout_p  = (64'(pout_pr) + 64'sd8388608) >>> 24;

  // Colour mix.
  logic signed [17:0] inv_s, mix_s, blend_s, gain_s;
  logic signed [55:0] mix_acc, blend_acc, gain_acc;
  logic signed [NB-1:0] mix_res, white_w;
  assign inv_s   = $signed({1'b0, ONE_Q16 - mix_c});
  assign mix_s   = $signed({1'b0, mix_c});
  assign blend_s = $signed({1'b0, blend_c});
  assign gain_s  = $signed({1'b0, gain_c});
  assign white_w = NB'(white_r);
  assign mix_acc = inv_s * white_r + mix_s * pink_r + 56'sd32768;
  assign mix_res = (sts.white_only) ? white_w : NB'(mix_acc >>> 16);

  // Mono mean over the channels, truncated toward zero.
  logic signed [NB-1:0] nz_sum;
  always_comb begin
    nz_sum = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) nz_sum = nz_sum + nz_r[c];
  end

  logic signed [NB-1:0] diff_w, blend_w, gain_w, s_adj, y_w;
  logic signed [PB-1:0] diff_n, bres_n;
  assign diff_w    = nz_r[ch_r] - mono_r;
  assign diff_n    = diff_w[PB-1:0];
  assign blend_acc = blend_s * diff_n + 56'sd32768;
  assign blend_w   = mono_r + NB'(blend_acc >>> 16);
  assign bres_n    = blend_res_r[PB-1:0];
  assign gain_acc  = bres_n * gain_s + 56'sd32768;
  assign gain_w    = NB'(gain_acc >>> 16);
  assign s_adj   = (SAMPLE_BITS >= 24) ? (s_r <<< SHIFT_UP)
                 : ((s_r + (NB'(1) <<< (SHIFT_DN - 1))) >>> SHIFT_DN);
  assign y_w     = sat_out(NB'(x_r[ch_r]) + s_adj);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      mix_r   <= '0;
      blend_r <= '0;
      rng_r   <= 32'd1;
      ch_r    <= '0;
      busy_r  <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++)
        for (int k = 0; k < 7; k++) taps_r[c][k] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN:  gain_r  <= cfg_data[16:0];
          REG_COLOR: mix_r   <= cfg_data[16:0];
          REG_BLEND: blend_r <= cfg_data[16:0];
          REG_SEED:  rng_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) ch_r <= '0;
      if (cmd.draw) begin
        rng_r   <= rng_next;
        white_r <= $signed({1'b0, rng_next[31:8]}) - 25'sd8388608;
      end
      if (cmd.pole) taps_r[ch_r][cmd.tap_idx] <= pole_sat;
      if (cmd.pink_sum) begin
        acc_r <= sum_acc[34:0];
        taps_r[ch_r][6] <= last_rnd[TAP_BITS-1:0];
      end
      if (cmd.pink_out) pink_r <= pout_p[PB-1:0];
      if (cmd.mix) nz_r[ch_r] <= mix_res;
      if (cmd.mono) begin
        mono_r <= nz_sum / NUM_CHANNELS;
        ch_r   <= '0;
      end
      if (cmd.next_ch) ch_r <= ch_r + CH_BITS'(1);
      if (cmd.blend) blend_res_r <= blend_w;
      if (cmd.gain) s_r <= gain_w;
      if (cmd.outp) y_r[ch_r] <= y_w[SAMPLE_BITS-1:0];
      if (cmd.present) busy_r <= 1'b1;
      else if (out_ready) busy_r <= 1'b0;
    end
  end

  // Bypass presents the captured input; otherwise the computed samples.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r[0] <= in_left_in;
      if (NUM_CHANNELS > 1) x_r[NUM_CHANNELS-1] <= in_right_in;
    end
    if (cmd.present) begin
      out_left_out  <= sts.bypass ? x_r[0] : y_r[0];
      out_right_out <= sts.bypass ? x_r[NUM_CHANNELS-1] : y_r[NUM_CHANNELS-1];
    end
  end

  assign out_valid = busy_r;
endmodule

// ===== hdl/stereo_hiss_noise_injector.sv =====
// Top level of the stereo hiss noise injector.
// Depends on shni_pkg, shni_ctrl and shni_dp.
//
// Usage: one stereo word (in_left_in, in_right_in) is taken on the input
// valid/ready channel and one word (out_left_out, out_right_out) is returned
// on the output channel, carrying each sample plus scaled synthetic hiss,
// saturated to the sample width.
// The configuration port writes gain, colour mix, stereo blend and the seed
// of the noise generator; a seed write reloads the generator at once.
// With gain zero the word is passed through unchanged. Otherwise the
// sequencer, which steps one channel at a time, one arithmetic step a cycle,
// draws white noise for each channel; pink colouring adds six pole-tap
// updates, the tap sum and the output scaling per channel. It then forms the
// mono mean and blends, scales and stores each channel. A word is finished
// before the next one is taken.
// Reset clears the registers to gain 0, mix 0, blend 0, seed 1 and zeroes
// every pink tap. A finished word waits in the output register while the
// receiver stalls; no new word is taken until it has been delivered.
module stereo_hiss_noise_injector #(
  parameter int SAMPLE_BITS  = shni_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [shni_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [shni_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]      in_right_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_left_out,
  output logic signed [SAMPLE_BITS-1:0]      out_right_out
);
  import shni_pkg::*;

  shni_cmd_t cmd;
  shni_sts_t sts;

  // The controller holds off while a finished word still waits for the receiver.
  shni_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_busy (out_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  shni_dp #(
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

endmodule
